[rtl/core/sdepq_pkg.sv]
// ----------------------------------------------------------------------------
// sdepq_pkg
// Shared codes and types for the sorted double-ended priority queue.
// ----------------------------------------------------------------------------
package sdepq_pkg;

	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int CAP_W   = 5;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	// operation codes
	localparam func_t FUNC_INSERT   = 2'd0;
	localparam func_t FUNC_TAKE_MAX = 2'd1;
	localparam func_t FUNC_TAKE_MIN = 2'd2;

	// status codes
	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// control broadcast to every cell for one item
	typedef struct packed {
		logic insert;
		logic take_max;
	} cell_ctrl_t;

endpackage

[rtl/core/sdepq_ifs.sv]
// ----------------------------------------------------------------------------
// sdepq_ifs
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface sdepq_in_if;
	import sdepq_pkg::*;
	logic   valid;
	logic   ready;
	func_t  func;
	value_t value;

	modport source(output valid, output func, output value, input ready);
	modport sink(input valid, input func, input value, output ready);
endinterface

interface sdepq_out_if;
	import sdepq_pkg::*;
	logic             valid;
	logic             ready;
	value_t           taken_value;
	status_t          status;
	logic [CAP_W-1:0] count_after;

	modport source(output valid, output taken_value, output status, output count_after,
		input ready);
	modport sink(input valid, input taken_value, input status, input count_after,
		output ready);
endinterface

[rtl/core/sdepq_cell.sv]
// ----------------------------------------------------------------------------
// sdepq_cell
// One slot of the sorted chain: holds one entry and trades it with neighbors.
// ----------------------------------------------------------------------------
module sdepq_cell (
	input  logic                clk,
	input  sdepq_pkg::cell_ctrl_t ctrl,
	input  sdepq_pkg::value_t   ins_value,
	input  logic                occ,
	input  sdepq_pkg::value_t   left_entry,
	input  logic                left_le,
	input  sdepq_pkg::value_t   right_entry,
	output sdepq_pkg::value_t   entry,
	output logic                le
);
	import sdepq_pkg::*;

	value_t entry_q;

	// flag a held entry that the new value goes in front of
	assign le    = occ && (entry_q <= ins_value);
	assign entry = entry_q;

	// shift right on insert behind the slot, load the value at the slot, shift left on take-max
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (left_le) begin
				entry_q <= left_entry;
			end else if (le || !occ) begin
				entry_q <= ins_value;
			end
		end else if (ctrl.take_max) begin
			entry_q <= right_entry;
		end
	end

endmodule

[rtl/core/sorted_double_ended_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_double_ended_priority_queue_top
// Sorted double-ended priority queue: DEPTH cells hold signed 32-bit values in
// descending order, each cell comparing its entry with the incoming value and
// shifting toward its neighbor in the same cycle (none on take-min), so an item
// is accepted every clock and its result enters the output register in the next
// cycle; throughput is one item per cycle, limited only by the output handshake.
// cfg_wdata sets the capacity (reset 16, saturated at DEPTH); inserts past it
// are dropped with status full, takes from an empty queue return status empty.
// ----------------------------------------------------------------------------
module sorted_double_ended_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [sdepq_pkg::CAP_W-1:0] cfg_wdata,
	sdepq_in_if.sink                   in_ch,
	sdepq_out_if.source                out_ch
);
	import sdepq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	value_t           taken_q;
	status_t          status_q;
	logic [CAP_W-1:0] count_out_q;

	logic             accept;
	logic [CMP_W-1:0] cap_lim;
	logic [CMP_W-1:0] count_ext;
	logic             empty;
	logic             can_ins;
	cell_ctrl_t       ctrl;
	logic [CNT_W-1:0] count_nxt;
	value_t           taken_nxt;
	status_t          status_nxt;
	value_t           min_entry;

	logic   [DEPTH-1:0] occ;
	logic   [DEPTH-1:0] le;
	value_t             entries [DEPTH];

	// take a new item whenever the output register is free or draining
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// effective capacity and occupancy
	assign cap_lim   = (CMP_W'(cap_q) > DEPTH_C) ? DEPTH_C : CMP_W'(cap_q);
	assign count_ext = CMP_W'(count_q);
	assign empty     = (count_q == '0);
	assign can_ins   = count_ext < cap_lim;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = CNT_W'(i) < count_q;
		end
	end

	// back entry for take-min: the last occupied cell
	always_comb begin
		min_entry = '0;
		for (int i = 0; i < DEPTH - 1; i++) begin
			if (occ[i] && !occ[i+1]) begin
				min_entry = entries[i];
			end
		end
		if (occ[DEPTH-1]) begin
			min_entry = entries[DEPTH-1];
		end
	end

	// decode the item into cell control, result and next count
	always_comb begin
		ctrl       = '0;
		count_nxt  = count_q;
		taken_nxt  = '0;
		status_nxt = ST_DONE;
		case (in_ch.func)
			FUNC_INSERT: begin
				if (can_ins) begin
					ctrl.insert = accept;
					count_nxt   = count_q + 1'b1;
				end else begin
					status_nxt = ST_FULL;
				end
			end
			FUNC_TAKE_MAX: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					ctrl.take_max = accept;
					taken_nxt     = entries[0];
					count_nxt     = count_q - 1'b1;
				end
			end
			FUNC_TAKE_MIN: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					taken_nxt = min_entry;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// chain of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		value_t left_e;
		logic   left_f;
		value_t right_e;

		if (g == 0) begin : g_first
			assign left_e = '0;
			assign left_f = 1'b0;
		end else begin : g_mid
			assign left_e = entries[g-1];
			assign left_f = le[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_e = entries[g];
		end else begin : g_inner
			assign right_e = entries[g+1];
		end

		sdepq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.ins_value  (in_ch.value),
			.occ        (occ[g]),
			.left_entry (left_e),
			.left_le    (left_f),
			.right_entry(right_e),
			.entry      (entries[g]),
			.le         (le[g])
		);
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// advance the count and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taken_q     <= taken_nxt;
			status_q    <= status_nxt;
			count_out_q <= CAP_W'(count_nxt);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.taken_value = taken_q;
	assign out_ch.status      = status_q;
	assign out_ch.count_after = count_out_q;

endmodule

[rtl/core/sdepq_checker.sv]
// ----------------------------------------------------------------------------
// sdepq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module sdepq_checker #(
	parameter int DEPTH = 16
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input sdepq_pkg::value_t           taken_value,
	input sdepq_pkg::status_t          status,
	input logic [sdepq_pkg::CAP_W-1:0] count_after
);
	import sdepq_pkg::*;

	// largest count the queue can report
	localparam logic [CAP_W-1:0] CNT_MAX = (DEPTH > 31) ? '1 : CAP_W'(DEPTH);

	// a waiting result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// count never exceeds the capacity range
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_after <= CNT_MAX)
		else $error("count out of range");

	// a failed operation returns zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_EMPTY) |-> taken_value == '0)
		else $error("nonzero value on failed operation");

	// empty take reports zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> count_after == '0)
		else $error("empty status with entries held");

endmodule

bind sorted_double_ended_priority_queue_top sdepq_checker #(
	.DEPTH(DEPTH)
) u_sdepq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.taken_value(out_ch.taken_value),
	.status     (out_ch.status),
	.count_after(out_ch.count_after)
);

[verif/sdepq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdepq_tb_checker
// Watches the operation and result channels of the sorted double-ended
// priority queue, keeps its own sorted copy of the queue contents and the
// capacity register, and compares every result item with the outcome owed
// by the oldest outstanding operation.
// ----------------------------------------------------------------------------
module sdepq_tb_checker #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sdepq_pkg::CAP_W-1:0] cfg_wdata,
	sdepq_in_if                         ops,
	sdepq_out_if                        res,
	output int                          mismatches,
	output int                          outcomes_owed,
	output int                          results_seen,
	output int                          drops_seen,
	output int                          empties_seen
);
	import sdepq_pkg::*;

	typedef struct packed {
		value_t           taken;
		status_t          status;
		logic [CAP_W-1:0] count;
	} outcome_t;

	// shadow copy of the queue, largest value at index 0
	value_t           shadow_entries [DEPTH];
	int unsigned      shadow_count;
	logic [CAP_W-1:0] shadow_capacity;
	outcome_t         outcome_fifo [$];

	// apply one operation to the shadow queue and return its outcome
	function automatic outcome_t apply_queue_op(input func_t op, input value_t v);
		outcome_t    r;
		int unsigned limit;
		int unsigned slot;
		r.taken  = '0;
		r.status = ST_DONE;
		limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
		case (op)
			FUNC_INSERT: begin
				if (shadow_count >= limit) begin
					r.status = ST_FULL;
				end else begin
					// land in front of the first entry that is not larger
					slot = shadow_count;
					for (int i = 0; i < shadow_count; i++) begin
						if (slot == shadow_count && shadow_entries[i] <= v)
							slot = i;
					end
					for (int i = shadow_count; i > slot; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[slot] = v;
					shadow_count++;
				end
			end
			FUNC_TAKE_MAX: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.taken = shadow_entries[0];
					for (int i = 1; i < shadow_count; i++)
						shadow_entries[i-1] = shadow_entries[i];
					shadow_count--;
				end
			end
			FUNC_TAKE_MIN: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.taken = shadow_entries[shadow_count-1];
					shadow_count--;
				end
			end
			default: ;
		endcase
		r.count = shadow_count[CAP_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		outcome_t fresh;
		int       fails;
		if (!arst_n) begin
			shadow_count    = 0;
			shadow_capacity = CAP_RESET;
			outcome_fifo.delete();
			mismatches    <= 0;
			outcomes_owed <= 0;
			results_seen  <= 0;
			drops_seen    <= 0;
			empties_seen  <= 0;
		end else begin
			fails = 0;
			// check a result item against the oldest owed outcome
			if (res.valid && res.ready) begin
				results_seen <= results_seen + 1;
				if (outcome_fifo.size() == 0) begin
					$error("result item with no operation outstanding: taken_value %0d",
						res.taken_value);
					fails++;
				end else begin
					want = outcome_fifo.pop_front();
					if (res.taken_value !== want.taken) begin
						$error("taken_value: expected %0d, got %0d", want.taken,
							res.taken_value);
						fails++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						fails++;
					end
					if (res.count_after !== want.count) begin
						$error("count_after: expected %0d, got %0d", want.count,
							res.count_after);
						fails++;
					end
				end
			end
			// predict the outcome of an accepted operation item
			if (ops.valid && ops.ready) begin
				fresh = apply_queue_op(ops.func, ops.value);
				outcome_fifo.push_back(fresh);
				if (fresh.status == ST_FULL)
					drops_seen <= drops_seen + 1;
				if (fresh.status == ST_EMPTY)
					empties_seen <= empties_seen + 1;
			end
			// track the capacity register
			if (cfg_we)
				shadow_capacity = cfg_wdata;
			mismatches    <= mismatches + fails;
			outcomes_owed <= outcome_fifo.size();
		end
	end

endmodule

[verif/tb_sorted_double_ended_priority_queue_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_double_ended_priority_queue_top
// Drives insert, take-max, take-min and unused operations into the queue
// under a series of capacity settings, with random gaps on both channels, a
// stretch with no gaps and one long hold-off of the result channel. The
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_sorted_double_ended_priority_queue_top;
	import sdepq_pkg::*;

	localparam int    DEPTH       = 16;
	localparam int    PHASE_ITEMS = 86;
	localparam int    HOLD_CYCLES = 300;
	localparam int    CYCLE_LIMIT = 200000;
	localparam func_t FUNC_UNUSED = 2'd3;
	localparam value_t VAL_MAX    = 32'sh7FFF_FFFF;
	localparam value_t VAL_MIN    = 32'sh8000_0000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             steady;
	logic             pressure_go;
	int               cycles = 0;
	int               mismatches;
	int               outcomes_owed;
	int               results_seen;
	int               drops_seen;
	int               empties_seen;

	sdepq_in_if  ops_ch();
	sdepq_out_if res_ch();

	sorted_double_ended_priority_queue_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (ops_ch),
		.out_ch   (res_ch)
	);

	sdepq_tb_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.ops          (ops_ch),
		.res          (res_ch),
		.mismatches   (mismatches),
		.outcomes_owed(outcomes_owed),
		.results_seen (results_seen),
		.drops_seen   (drops_seen),
		.empties_seen (empties_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outcomes still owed", cycles,
				outcomes_owed);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off when asked
	initial begin : result_side
		bit held_off;
		held_off = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			if (pressure_go && !held_off) begin
				held_off = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= steady || ($urandom_range(99) >= 10);
				@(posedge clk);
			end
		end
	end

	// offer one operation item and hold it until accepted
	task automatic send_op(input func_t op, input value_t v);
		if (!steady) begin
			while ($urandom_range(99) < 10) begin
				ops_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		ops_ch.valid <= 1'b1;
		ops_ch.func  <= op;
		ops_ch.value <= v;
		do @(posedge clk); while (!ops_ch.ready);
	endtask

	// stop offering and wait until every owed result has come back
	task automatic drain_queue;
		ops_ch.valid <= 1'b0;
		do @(posedge clk); while (outcomes_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] c);
		drain_queue();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly full-range values, with ties and extremes mixed in
	function automatic value_t pick_value();
		value_t extremes [4];
		extremes = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1};
		case ($urandom_range(7))
			0:       return extremes[$urandom_range(3)];
			1, 2:    return $signed($urandom_range(6)) - 32'sd3;
			default: return $urandom;
		endcase
	endfunction

	function automatic func_t pick_op(input int insert_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return FUNC_UNUSED;
		if (roll < 3 + insert_pct)
			return FUNC_INSERT;
		return $urandom_range(1) ? FUNC_TAKE_MAX : FUNC_TAKE_MIN;
	endfunction

	initial begin : stimulus
		logic [CAP_W-1:0] caps [12];
		int               insert_pct;
		caps = '{5'd16, 5'd1, 5'd31, 5'd8, 5'd0, 5'd16, 5'd3, 5'd20, 5'd2, 5'd16,
			5'd12, 5'd5};
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		ops_ch.valid <= 1'b0;
		ops_ch.func  <= FUNC_INSERT;
		ops_ch.value <= '0;
		steady       <= 1'b0;
		pressure_go  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// take from empty, unused code, then fill with extremes and ties
		send_op(FUNC_TAKE_MAX, 32'sd0);
		send_op(FUNC_TAKE_MIN, VAL_MAX);
		send_op(FUNC_UNUSED, -32'sd1);
		send_op(FUNC_INSERT, VAL_MAX);
		send_op(FUNC_INSERT, VAL_MIN);
		send_op(FUNC_INSERT, 32'sd0);
		send_op(FUNC_INSERT, -32'sd1);
		send_op(FUNC_INSERT, 32'sd0);
		send_op(FUNC_INSERT, VAL_MAX);
		send_op(FUNC_INSERT, 32'sd5);
		send_op(FUNC_INSERT, VAL_MIN);
		send_op(FUNC_UNUSED, 32'sh5A5A_5A5A);
		send_op(FUNC_TAKE_MAX, 32'sd0);
		send_op(FUNC_TAKE_MAX, 32'sd0);
		send_op(FUNC_TAKE_MIN, 32'sd0);
		send_op(FUNC_TAKE_MIN, 32'sd0);

		// capacity zero with entries still held: drop inserts, takes still work
		set_capacity(5'd0);
		send_op(FUNC_INSERT, 32'sd7);
		send_op(FUNC_TAKE_MIN, 32'sd0);
		send_op(FUNC_TAKE_MAX, 32'sd0);
		send_op(FUNC_TAKE_MIN, 32'sd0);
		send_op(FUNC_TAKE_MAX, 32'sd0);
		send_op(FUNC_TAKE_MIN, 32'sd0);

		// random phases: fill, drain and balanced mixes under each capacity
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			steady      <= (p == 5);
			pressure_go <= (p == 9);
			case (p % 3)
				0:       insert_pct = 70;
				1:       insert_pct = 32;
				default: insert_pct = 48;
			endcase
			repeat (PHASE_ITEMS) send_op(pick_op(insert_pct), pick_value());
		end
		drain_queue();

		$display("Ran %0d operations over capacities 0 through 31, gap-free and held-off",
			results_seen);
		$display("stretches included: %0d inserts dropped full, %0d takes from empty",
			drops_seen, empties_seen);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
